>>> rtl/msfp_pkg.sv
// Shared types, constants and codes of the multichannel sample frame parser.
package msfp_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 4;
  localparam int unsigned NUM_CHANNELS    = 8;
  localparam int unsigned HEADER_BYTES    = 6;
  localparam int unsigned CFG_INDEX_W     = 2;
  localparam int unsigned CFG_DATA_W      = 8;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_MAGIC     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_VERSION   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_COUNT = 2'd2;

  localparam logic [7:0] MAGIC_RESET     = 8'hA5;
  localparam logic [7:0] VERSION_RESET   = 8'h01;
  localparam logic [7:0] MAX_COUNT_RESET = 8'd20;

  // header byte positions
  localparam logic [15:0] POS_MAGIC   = 16'd0;
  localparam logic [15:0] POS_VERSION = 16'd1;
  localparam logic [15:0] POS_SEQ_LO  = 16'd2;
  localparam logic [15:0] POS_SEQ_HI  = 16'd3;
  localparam logic [15:0] POS_COUNT   = 16'd4;

  // lane of the high byte of the last channel in a sample
  localparam logic [3:0] LAST_LANE = 4'hF;

  typedef enum logic [2:0] {
    ST_SAMPLE     = 3'd0,
    ST_LAST       = 3'd1,
    ST_BAD_HEADER = 3'd2,
    ST_BAD_COUNT  = 3'd3,
    ST_TOO_SHORT  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'b001,
    MODE_HEADER  = 3'b010,
    MODE_SAMPLES = 3'b100
  } mode_t;

  typedef enum logic {
    OP_STATUS = 1'b0,
    OP_CHAN   = 1'b1
  } op_kind_t;

  typedef struct packed {
    logic [7:0] magic;
    logic [7:0] version;
    logic [7:0] max_count;
  } cfg_t;

  // one classified byte handed from front to back
  typedef struct packed {
    op_kind_t    kind;
    status_t     status;
    logic [15:0] seq;
    logic [7:0]  idx;
    logic [7:0]  flags;
    logic [3:0]  lane;
    logic [7:0]  data;
  } op_t;

endpackage

>>> rtl/msfp_in_if.sv
// Input byte channel of the frame parser.
interface msfp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        frame_start;
  logic [15:0] frame_length;

  modport source (output valid, data_byte, frame_start, frame_length, input ready);
  modport sink   (input valid, data_byte, frame_start, frame_length, output ready);
endinterface

>>> rtl/msfp_out_if.sv
// Result channel of the frame parser.
interface msfp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [15:0]        sequence_number;
  logic [7:0]         sample_index;
  logic [7:0]         frame_flags;
  logic signed [15:0] channel_0;
  logic signed [15:0] channel_1;
  logic signed [15:0] channel_2;
  logic signed [15:0] channel_3;
  logic signed [15:0] channel_4;
  logic signed [15:0] channel_5;
  logic signed [15:0] channel_6;
  logic signed [15:0] channel_7;

  modport source (output valid, status, sequence_number, sample_index, frame_flags,
                  channel_0, channel_1, channel_2, channel_3, channel_4, channel_5,
                  channel_6, channel_7, input ready);
  modport sink   (input valid, status, sequence_number, sample_index, frame_flags,
                  channel_0, channel_1, channel_2, channel_3, channel_4, channel_5,
                  channel_6, channel_7, output ready);
endinterface

>>> rtl/msfp_front.sv
// Front end: frame tracking, header checks and byte classification.
module msfp_front import msfp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  msfp_in_if.sink      in_chan,
  input  logic         q_full,
  output logic         push,
  output op_t          op
);

  mode_t       mode_r, mode_nxt;
  logic [15:0] pos_r, pos_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [7:0]  cur_r, cur_nxt;

  logic        acc;
  logic [16:0] need_len;
  logic [8:0]  cur_inc;

  assign in_chan.ready = !q_full;
  assign acc = in_chan.valid && !q_full;
  // 6 + 16 * count
  assign need_len = 17'({count_r, 4'b0000}) + 17'(HEADER_BYTES);
  assign cur_inc  = {1'b0, cur_r} + 9'd1;

  always_comb begin
    mode_t       mode_eff;
    logic        work;
    logic [15:0] p;
    logic [7:0]  d;
    logic [3:0]  k;
    logic        last;

    mode_nxt  = mode_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    seq_nxt   = seq_r;
    count_nxt = count_r;
    flags_nxt = flags_r;
    cur_nxt   = cur_r;
    push      = 1'b0;
    op        = '0;
    mode_eff  = mode_r;
    work      = 1'b0;
    p         = pos_r;
    d         = in_chan.data_byte;
    k         = 4'd0;
    last      = 1'b0;

    if (acc) begin
      if (in_chan.frame_start) begin
        p       = '0;
        len_nxt = in_chan.frame_length;
        if (in_chan.frame_length < 16'(HEADER_BYTES)) begin
          mode_nxt = MODE_IDLE;   // short frame, dropped silently
        end else begin
          mode_eff = MODE_HEADER;
          work     = 1'b1;
        end
      end else if (mode_r != MODE_IDLE) begin
        work = 1'b1;
      end

      if (work) begin
        pos_nxt  = p + 16'd1;
        mode_nxt = mode_eff;
        case (mode_eff)
          MODE_HEADER: begin
            if (p == POS_MAGIC) begin
              if (d != cfg.magic) begin
                mode_nxt  = MODE_IDLE;
                push      = 1'b1;
                op.kind   = OP_STATUS;
                op.status = ST_BAD_HEADER;
              end
            end else if (p == POS_VERSION) begin
              if (d != cfg.version) begin
                mode_nxt  = MODE_IDLE;
                push      = 1'b1;
                op.kind   = OP_STATUS;
                op.status = ST_BAD_HEADER;
              end
            end else if (p == POS_SEQ_LO) begin
              seq_nxt = {8'h00, d};
            end else if (p == POS_SEQ_HI) begin
              seq_nxt = {d, seq_r[7:0]};
            end else if (p == POS_COUNT) begin
              count_nxt = d;
            end else begin
              // flags byte closes the header
              flags_nxt = d;
              mode_nxt  = MODE_IDLE;
              op.seq    = seq_r;
              op.flags  = d;
              op.kind   = OP_STATUS;
              if (count_r == 8'd0 || count_r > cfg.max_count) begin
                push      = 1'b1;
                op.status = ST_BAD_COUNT;
              end else if ({1'b0, len_r} < need_len) begin
                push      = 1'b1;
                op.status = ST_TOO_SHORT;
              end else begin
                mode_nxt = MODE_SAMPLES;
                cur_nxt  = 8'd0;
              end
            end
          end
          MODE_SAMPLES: begin
            k        = p[3:0] - 4'(HEADER_BYTES);
            push     = 1'b1;
            op.kind  = OP_CHAN;
            op.lane  = k;
            op.data  = d;
            op.seq   = seq_r;
            op.flags = flags_r;
            op.idx   = cur_r;
            last     = cur_inc >= {1'b0, count_r};
            op.status = last ? ST_LAST : ST_SAMPLE;
            if (k == LAST_LANE) begin
              if (last) begin
                mode_nxt = MODE_IDLE;
              end else begin
                cur_nxt = cur_inc[7:0];
              end
            end
          end
          default: begin
            mode_nxt = MODE_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      len_r   <= '0;
      seq_r   <= '0;
      count_r <= '0;
      flags_r <= '0;
      cur_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      seq_r   <= seq_nxt;
      count_r <= count_nxt;
      flags_r <= flags_nxt;
      cur_r   <= cur_nxt;
    end
  end

endmodule

>>> rtl/msfp_queue.sv
// Short queue of classified bytes between front and back.
module msfp_queue import msfp_pkg::*; #(
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output logic full,
  output logic q_valid,
  output op_t  head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  op_t           mem_r [DEPTH];
  logic [AW-1:0] wr_r, wr_nxt;
  logic [AW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = count_r == CW'(DEPTH);
  assign q_valid = count_r != '0;
  assign head    = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_nxt = (wr_r == LAST_SLOT) ? '0 : wr_r + AW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == LAST_SLOT) ? '0 : rd_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue fill count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> count_r == $past(count_r) + CW'(1))
    else $error("queue fill count missed a push");

endmodule

>>> rtl/msfp_back.sv
// Back end: channel assembly and the result register.
module msfp_back import msfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  op_t        head,
  output logic       pop,
  msfp_out_if.source out_chan
);

  logic [7:0]         low_r;
  logic [15:0]        ch_r     [NUM_CHANNELS];
  logic               out_valid_r;
  status_t            out_status_r;
  logic [15:0]        out_seq_r;
  logic [7:0]         out_idx_r;
  logic [7:0]         out_flags_r;
  logic signed [15:0] out_ch_r [NUM_CHANNELS];

  logic        emit, slot_free, is_chan;
  logic [15:0] word;
  logic [2:0]  word_slot;

  assign is_chan   = head.kind == OP_CHAN;
  assign emit      = q_valid && (!is_chan || head.lane == LAST_LANE);
  assign slot_free = !out_valid_r || out_chan.ready;
  assign pop       = q_valid && (!emit || slot_free);
  assign word      = {head.data, low_r};
  assign word_slot = head.lane[3:1];

  // channel assembly: even lane is the low byte, odd lane completes a word
  always_ff @(posedge clk) begin
    if (pop && is_chan) begin
      if (!head.lane[0]) begin
        low_r <= head.data;
      end else begin
        ch_r[word_slot] <= word;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_status_r <= head.status;
      out_seq_r    <= head.seq;
      out_flags_r  <= head.flags;
      out_idx_r    <= is_chan ? head.idx : 8'd0;
      for (int j = 0; j < NUM_CHANNELS; j++) begin
        if (!is_chan) begin
          out_ch_r[j] <= '0;
        end else if (3'(j) == word_slot) begin
          out_ch_r[j] <= word;
        end else begin
          out_ch_r[j] <= ch_r[j];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.status          = out_status_r;
  assign out_chan.sequence_number = out_seq_r;
  assign out_chan.sample_index    = out_idx_r;
  assign out_chan.frame_flags     = out_flags_r;
  assign out_chan.channel_0       = out_ch_r[0];
  assign out_chan.channel_1       = out_ch_r[1];
  assign out_chan.channel_2       = out_ch_r[2];
  assign out_chan.channel_3       = out_ch_r[3];
  assign out_chan.channel_4       = out_ch_r[4];
  assign out_chan.channel_5       = out_ch_r[5];
  assign out_chan.channel_6       = out_ch_r[6];
  assign out_chan.channel_7       = out_ch_r[7];

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && emit) |=> out_valid_r)
    else $error("result popped but not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && !slot_free) |-> !pop)
    else $error("result popped over a waiting result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_status_r == ST_SAMPLE || out_status_r == ST_LAST ||
                     out_status_r == ST_BAD_HEADER || out_status_r == ST_BAD_COUNT ||
                     out_status_r == ST_TOO_SHORT))
    else $error("result carries an unknown status");

endmodule

>>> rtl/multichannel_sample_frame_parser.sv
// Top level of the multichannel sample frame parser.
//
// Takes one frame byte per item and accepts a new byte every clock cycle while
// the queue is not full. The front end tracks frame position and checks the
// header in the cycle a byte is taken; it hands each meaningful byte to a short
// queue (QUEUE_DEPTH entries, default 4). The back end assembles the eight
// little-endian channels and loads finished results into an output register;
// in_chan.ready only falls when the queue is full while the result register is
// held by the sink. A complete sample gives one result (status sample or last
// sample); a bad magic or version byte gives a bad header status at that byte;
// a bad count or a frame too short for its count gives one status at the flags
// byte. Frames shorter than the six header bytes, stray bytes between frames
// and trailing bytes are dropped without a result. Configuration (magic,
// version, sample count limit) is written through cfg_we/cfg_index/cfg_data;
// the user must write it only while idle, which the block does not enforce.
module multichannel_sample_frame_parser import msfp_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  msfp_in_if.sink                in_chan,
  msfp_out_if.source             out_chan,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg_r;
  logic push, pop, q_full, q_valid;
  op_t  push_op, head;

  // register file; writes to unused indexes fall away
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic     <= MAGIC_RESET;
      cfg_r.version   <= VERSION_RESET;
      cfg_r.max_count <= MAX_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAGIC:     cfg_r.magic     <= cfg_data;
        CFG_VERSION:   cfg_r.version   <= cfg_data;
        CFG_MAX_COUNT: cfg_r.max_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // header parse and byte classification
  msfp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_chan (in_chan),
    .q_full  (q_full),
    .push    (push),
    .op      (push_op)
  );

  // decouples the byte stream from result back-pressure
  msfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .full    (q_full),
    .q_valid (q_valid),
    .head    (head)
  );

  // channel assembly and result register
  msfp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .out_chan (out_chan)
  );

endmodule

>>> dv/tb_multichannel_sample_frame_parser.sv
// Self-checking testbench for the multichannel sample frame parser.
`timescale 1ns / 1ps

module tb_multichannel_sample_frame_parser import msfp_pkg::*; ();

  // Quiet cycles (no item moving on either channel) before the run is abandoned.
  // The longest legal quiet stretch is a long input gap inside a long sink stall, or
  // the settling before a row of register writes.
  localparam int WATCHDOG_LIMIT = 4000;
  // Cycles let pass after the last expected result before a register write: bytes
  // that give no result may still sit in the parser's short queue.
  localparam int SETTLE_CYCLES  = 16;

  // one byte item as offered on the input channel
  typedef struct packed {
    logic [7:0]  data;
    logic        start;
    logic [15:0] len;
  } raw_byte_t;

  // one result item, field for field as on the result channel
  typedef struct packed {
    status_t          status;
    logic [15:0]      seq;
    logic [7:0]       idx;
    logic [7:0]       flags;
    logic [7:0][15:0] chan;
  } frame_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  // source side, driven from the clocked driver below
  logic        drv_valid = 1'b0;
  logic [7:0]  drv_data  = '0;
  logic        drv_start = 1'b0;
  logic [15:0] drv_len   = '0;
  // sink side
  logic        sink_ready = 1'b0;

  msfp_in_if  in_chan ();
  msfp_out_if out_chan ();

  assign in_chan.valid        = drv_valid;
  assign in_chan.data_byte    = drv_data;
  assign in_chan.frame_start  = drv_start;
  assign in_chan.frame_length = drv_len;
  assign out_chan.ready       = sink_ready;

  multichannel_sample_frame_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the configuration registers, updated at the write edge
  // ---------------------------------------------------------------------------
  logic [7:0] sh_magic   = MAGIC_RESET;
  logic [7:0] sh_version = VERSION_RESET;
  logic [7:0] sh_max     = MAX_COUNT_RESET;

  // ---------------------------------------------------------------------------
  // Frame parser prediction state
  // ---------------------------------------------------------------------------
  mode_t            pm_mode   = MODE_IDLE;
  logic [15:0]      pm_pos    = '0;   // position of the next byte in the frame
  logic [15:0]      pm_len    = '0;   // frame length taken from the start byte
  logic [15:0]      pm_seq    = '0;
  logic [7:0]       pm_cnt    = '0;
  logic [7:0]       pm_flags  = '0;
  logic [7:0]       pm_idx    = '0;   // sample being assembled
  logic [7:0]       pm_lo     = '0;   // low byte waiting for its high byte
  logic [7:0][15:0] pm_chan   = '0;

  raw_byte_t     pend_q[$];   // bytes waiting to be offered
  frame_result_t want_q[$];   // results the parser owes us, oldest first

  // idling knobs, percent chance of a gap after an item / of a sink stall
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int gap_left      = 0;
  int stall_left    = 0;

  int n_fail      = 0;
  int n_bytes     = 0;
  int n_samples   = 0;
  int n_lasts     = 0;
  int n_status    = 0;
  int quiet_cycles = 0;
  int phase_bytes = 0;

  // Works out what one accepted byte causes and queues the result, if any.
  task automatic parse_byte(input logic [7:0] d, input logic st, input logic [15:0] fl);
    logic [15:0]   p;
    logic [3:0]    lane;
    frame_result_t r;
    r = '0;
    if (st) begin
      // a start mark always restarts, even in the middle of a frame
      pm_mode = MODE_HEADER;
      pm_pos  = '0;
      pm_len  = fl;
      if (fl < HEADER_BYTES) begin
        pm_mode = MODE_IDLE;   // too short to hold a header: dropped silently
        return;
      end
    end else if (pm_mode != MODE_HEADER && pm_mode != MODE_SAMPLES) begin
      pm_mode = MODE_IDLE;     // stray or trailing byte
      return;
    end

    p      = pm_pos;
    pm_pos = p + 16'd1;

    if (pm_mode == MODE_HEADER) begin
      case (p)
        POS_MAGIC: begin
          if (d != sh_magic) begin
            pm_mode  = MODE_IDLE;
            r.status = ST_BAD_HEADER;
            want_q.push_back(r);
          end
        end
        POS_VERSION: begin
          if (d != sh_version) begin
            pm_mode  = MODE_IDLE;
            r.status = ST_BAD_HEADER;
            want_q.push_back(r);
          end
        end
        POS_SEQ_LO: pm_seq = {8'h00, d};
        POS_SEQ_HI: pm_seq[15:8] = d;
        POS_COUNT:  pm_cnt = d;
        default: begin
          // flags byte closes the header; count and length are judged here
          pm_flags = d;
          pm_mode  = MODE_IDLE;
          r.seq    = pm_seq;
          r.flags  = pm_flags;
          if (pm_cnt == 8'd0 || pm_cnt > sh_max) begin
            r.status = ST_BAD_COUNT;
            want_q.push_back(r);
          end else if (int'(pm_len) < int'(HEADER_BYTES) + 16 * int'(pm_cnt)) begin
            r.status = ST_TOO_SHORT;
            want_q.push_back(r);
          end else begin
            pm_mode = MODE_SAMPLES;
            pm_idx  = '0;
          end
        end
      endcase
    end else begin
      lane = 4'(p - 16'(HEADER_BYTES));
      if (!lane[0]) begin
        pm_lo = d;
      end else begin
        pm_chan[lane[3:1]] = {d, pm_lo};
        if (lane == LAST_LANE) begin
          r.status = (9'(pm_idx) + 9'd1 >= 9'(pm_cnt)) ? ST_LAST : ST_SAMPLE;
          r.seq    = pm_seq;
          r.idx    = pm_idx;
          r.flags  = pm_flags;
          r.chan   = pm_chan;
          want_q.push_back(r);
          if (r.status == ST_LAST) pm_mode = MODE_IDLE;
          else pm_idx = pm_idx + 8'd1;
        end
      end
    end
  endtask

  task automatic compare_result(input frame_result_t want, input frame_result_t seen);
    int j;
    if (seen.status !== want.status) begin
      $display("%0t: status expected %0d got %0d", $time, want.status, seen.status);
      n_fail++;
    end
    if (seen.seq !== want.seq) begin
      $display("%0t: sequence_number expected %0d got %0d", $time, want.seq, seen.seq);
      n_fail++;
    end
    if (seen.idx !== want.idx) begin
      $display("%0t: sample_index expected %0d got %0d", $time, want.idx, seen.idx);
      n_fail++;
    end
    if (seen.flags !== want.flags) begin
      $display("%0t: frame_flags expected %0d got %0d", $time, want.flags, seen.flags);
      n_fail++;
    end
    for (j = 0; j < NUM_CHANNELS; j++) begin
      if (seen.chan[j] !== want.chan[j]) begin
        $display("%0t: channel_%0d expected %0d got %0d", $time, j,
                 $signed(want.chan[j]), $signed(seen.chan[j]));
        n_fail++;
      end
    end
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // sample bytes lean towards the values that make channel extremes
  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued bytes, predicts on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    raw_byte_t nxt;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && in_chan.ready) begin
        parse_byte(drv_data, drv_start, drv_len);
        n_bytes++;
      end
      if (!drv_valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          drv_valid <= 1'b0;
        end else if (pend_q.size() > 0) begin
          nxt = pend_q.pop_front();
          drv_data  <= nxt.data;
          drv_start <= nxt.start;
          drv_len   <= nxt.len;
          drv_valid <= 1'b1;
          gap_left = ($urandom_range(0, 99) < in_gap_pct) ? pick_len() : 0;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks every result item against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    frame_result_t seen, want;
    if (!rst_n) begin
      sink_ready <= 1'b0;
    end else begin
      if (out_chan.valid && sink_ready) begin
        seen.status  = status_t'(out_chan.status);
        seen.seq     = out_chan.sequence_number;
        seen.idx     = out_chan.sample_index;
        seen.flags   = out_chan.frame_flags;
        seen.chan[0] = out_chan.channel_0;
        seen.chan[1] = out_chan.channel_1;
        seen.chan[2] = out_chan.channel_2;
        seen.chan[3] = out_chan.channel_3;
        seen.chan[4] = out_chan.channel_4;
        seen.chan[5] = out_chan.channel_5;
        seen.chan[6] = out_chan.channel_6;
        seen.chan[7] = out_chan.channel_7;
        if (want_q.size() == 0) begin
          $display("%0t: unexpected result, expected none got status %0d seq %0d",
                   $time, seen.status, seen.seq);
          n_fail++;
        end else begin
          want = want_q.pop_front();
          compare_result(want, seen);
          case (want.status)
            ST_SAMPLE: n_samples++;
            ST_LAST: begin
              n_samples++;
              n_lasts++;
            end
            default: n_status++;
          endcase
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        sink_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < out_stall_pct) begin
        stall_left = pick_len() - 1;
        sink_ready <= 1'b0;
      end else begin
        sink_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: gives up when nothing moves for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watchdog
    if (!rst_n || (drv_valid && in_chan.ready) || (out_chan.valid && sink_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, want_q.size());
        $display("multichannel_sample_frame_parser test failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [7:0] d, input logic st, input logic [15:0] fl);
    raw_byte_t b;
    b.data  = d;
    b.start = st;
    b.len   = fl;
    pend_q.push_back(b);
    phase_bytes++;
  endtask

  // Queues the first n_send bytes of a frame. Only the start byte carries a
  // meaningful length; the rest carry noise there, which the parser ignores.
  task automatic send_frame(input logic [7:0] b0, input logic [7:0] b1,
                            input logic [15:0] seq, input logic [7:0] cnt,
                            input logic [7:0] flags, input logic [15:0] fl,
                            input int n_send);
    int i;
    logic [7:0] d;
    for (i = 0; i < n_send; i++) begin
      case (i)
        0: d = b0;
        1: d = b1;
        2: d = seq[7:0];
        3: d = seq[15:8];
        4: d = cnt;
        5: d = flags;
        default: d = pick_data();
      endcase
      if (i == 0) push_byte(d, 1'b1, fl);
      else push_byte(d, 1'b0, 16'($urandom));
    end
  endtask

  // One random frame. Most are well formed so that sample data is reached;
  // the rest are truncated, broken or plain noise.
  task automatic gen_frame();
    int kind, r, cnt_i, need, n_send, i;
    logic [15:0] fl;
    logic [7:0]  cnt, b0, b1;
    kind = $urandom_range(0, 99);
    r    = $urandom_range(0, 99);
    // the rare long frame is kept to twenty samples so phases stay short
    if ($urandom_range(0, 19) == 0)
      cnt_i = $urandom_range(1, (sh_max < 8'd20) ? int'(sh_max) : 20);
    else cnt_i = $urandom_range(1, (sh_max < 8'd4) ? int'(sh_max) : 4);
    cnt  = 8'(cnt_i);
    need = int'(HEADER_BYTES) + 16 * cnt_i;
    if (r < 50) fl = 16'(need);
    else if (r < 80) fl = 16'(need + $urandom_range(1, 8));
    else fl = 16'($urandom_range(need, 65535));
    b0 = sh_magic;
    b1 = sh_version;

    if (kind < 65) begin
      // complete frame, sometimes with trailing bytes
      send_frame(b0, b1, 16'($urandom), cnt, 8'($urandom), fl,
                 need + $urandom_range(0, 3));
    end else if (kind < 73) begin
      // cut short; the next start mark abandons it
      send_frame(b0, b1, 16'($urandom), cnt, 8'($urandom), fl,
                 $urandom_range(1, need - 1));
    end else if (kind < 78) begin
      do b0 = 8'($urandom); while (b0 == sh_magic);
      send_frame(b0, b1, 16'($urandom), cnt, 8'($urandom), fl, $urandom_range(1, 8));
    end else if (kind < 82) begin
      do b1 = 8'($urandom); while (b1 == sh_version);
      send_frame(b0, b1, 16'($urandom), cnt, 8'($urandom), fl, $urandom_range(2, 8));
    end else if (kind < 87) begin
      // count of zero, or above the limit where the limit leaves room
      if (sh_max == 8'hFF || $urandom_range(0, 2) == 0) cnt = 8'h00;
      else cnt = 8'($urandom_range(int'(sh_max) + 1, 255));
      send_frame(b0, b1, 16'($urandom), cnt, 8'($urandom), 16'($urandom),
                 $urandom_range(6, 10));
    end else if (kind < 92) begin
      // length does not cover the samples announced
      send_frame(b0, b1, 16'($urandom), cnt, 8'($urandom),
                 16'($urandom_range(6, need - 1)), $urandom_range(6, 10));
    end else if (kind < 96) begin
      // below header size: dropped, what follows is stray
      send_frame(b0, b1, 16'($urandom), cnt, 8'($urandom),
                 16'($urandom_range(0, 5)), $urandom_range(1, 4));
    end else begin
      n_send = $urandom_range(1, 6);
      for (i = 0; i < n_send; i++) push_byte(8'($urandom), 1'($urandom), 16'($urandom));
    end
  endtask

  task automatic run_phase(input int target);
    phase_bytes = 0;
    while (phase_bytes < target) gen_frame();
  endtask

  // Sender idles until the queue is empty and every expected result is in.
  task automatic wait_drained();
    do @(negedge clk); while (pend_q.size() != 0 || drv_valid || want_q.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAGIC:     sh_magic   = val;
      CFG_VERSION:   sh_version = val;
      CFG_MAX_COUNT: sh_max     = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [7:0] m, input logic [7:0] v, input logic [7:0] c);
    write_reg(CFG_MAGIC, m);
    write_reg(CFG_VERSION, v);
    write_reg(CFG_MAX_COUNT, c);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : test_sequence
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset register values
    in_gap_pct    = 20;
    out_stall_pct = 20;
    push_byte(8'h5A, 1'b0, 16'hFFFF);                         // stray byte while idle
    push_byte(MAGIC_RESET, 1'b1, 16'd5);                      // one short of a header
    push_byte(VERSION_RESET, 1'b0, 16'h0000);                 // now stray
    push_byte(MAGIC_RESET, 1'b1, 16'd0);                      // zero length
    send_frame(8'h00, 8'h00, 16'h0000, 8'd0, 8'h00, 16'hFFFF, 1);     // bad magic
    send_frame(MAGIC_RESET, 8'hFF, 16'h0000, 8'd0, 8'h00, 16'hFFFF, 2); // bad version
    // zero count, header fields at their top values
    send_frame(MAGIC_RESET, VERSION_RESET, 16'hFFFF, 8'd0, 8'hFF, 16'hFFFF, 6);
    // count one above the limit
    send_frame(MAGIC_RESET, VERSION_RESET, 16'h8001, MAX_COUNT_RESET + 8'd1, 8'h00,
               16'hFFFF, 6);
    // length one byte short of a single sample
    send_frame(MAGIC_RESET, VERSION_RESET, 16'h00FF, 8'd1, 8'h5A, 16'd21, 6);
    // header abandoned midway by the start mark of the next frame
    send_frame(MAGIC_RESET, VERSION_RESET, 16'h1234, 8'd1, 8'h00, 16'd22, 3);
    wait_drained();

    // Random part, reset values; the sender stops halfway until all is in
    in_gap_pct    = 30;
    out_stall_pct = 30;
    run_phase(150);
    wait_drained();
    run_phase(150);

    // lowest magic, highest version, single sample frames; no idling at all
    set_regs(8'h00, 8'hFF, 8'd1);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    run_phase(150);

    // widest count limit, one frame with a long sample count, heavy stalls
    set_regs(8'hFF, 8'h00, 8'd255);
    in_gap_pct    = 50;
    out_stall_pct = 60;
    send_frame(sh_magic, sh_version, 16'($urandom), 8'd60, 8'($urandom),
               16'(int'(HEADER_BYTES) + 16 * 60), int'(HEADER_BYTES) + 16 * 60);
    run_phase(150);

    // random register values, sink mostly stalling
    set_regs(8'($urandom), 8'($urandom), 8'($urandom_range(2, 16)));
    in_gap_pct    = 20;
    out_stall_pct = 70;
    run_phase(150);

    // back to the reset values, light idling
    set_regs(MAGIC_RESET, VERSION_RESET, MAX_COUNT_RESET);
    in_gap_pct    = 10;
    out_stall_pct = 10;
    run_phase(100);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d bytes under five register settings, %0d bad-header/count/length",
             n_bytes, n_status);
    $display("statuses and %0d samples in %0d completed frames", n_samples, n_lasts);
    if (n_fail == 0) begin
      $display("multichannel_sample_frame_parser test passed");
    end else begin
      $display("multichannel_sample_frame_parser test failed");
    end
    $finish;
  end

endmodule
